[design/front_coded_keyword_block_decoder_core_assert.svh]
// Assertion macros for the keyword block decoder.
// Clocked on clock, disabled in reset; no other dependencies.
`ifndef FRONT_CODED_KEYWORD_BLOCK_DECODER_CORE_ASSERT_SVH
`define FRONT_CODED_KEYWORD_BLOCK_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define FCKBD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fckbd assertion failed");

// next-cycle implication
`define FCKBD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fckbd assertion failed");

`endif

[design/fckbd_pkg.sv]
// Shared types and constants for the front-coded keyword block decoder.
// No dependencies.
package fckbd_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int STORE_AW    = 6;

   localparam logic [3:0] OFF_VARINT_MAX = 4'd10;
   localparam logic [3:0] CNT_VARINT_MAX = 4'd5;

   localparam logic CSR_IDX_SKIP = 1'b0;
   localparam logic CSR_IDX_HINT = 1'b1;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_MARKER = 1'b1;

   typedef enum logic [3:0] {
      ST_HEADER,
      ST_MATCH,
      ST_DELTA,
      ST_OFFSET,
      ST_DOCS,
      ST_HITS,
      ST_HINT,
      ST_SKIP,
      ST_DONE,
      ST_PREP,
      ST_RD,
      ST_LD
   } state_type;

   typedef struct packed {
      logic clr_block;
      logic hdr_long;
      logic start_short;
      logic start_long;
      logic wr_delta;
      logic vi_shift;
      logic vi_clr;
      logic ld_offset;
      logic ld_docs;
      logic ld_hits;
      logic ld_hint;
      logic ld_skip;
      logic clr_skip;
      logic marker;
      logic marker_err;
      logic emit_init;
      logic emit_rd;
      logic emit_ld;
   } cmd_type;

   typedef struct packed {
      logic hdr_zero;
      logic hdr_short;
      logic short_too_long;
      logic match_too_long;
      logic delta_last;
      logic vi_done;
      logic vi_ovf_off;
      logic vi_ovf_cnt;
      logic hint_go;
      logic skip_go;
      logic word_empty;
      logic emit_last;
      logic out_free;
   } sts_type;

endpackage

[design/fckbd_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
module fckbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/fckbd_ctrl.sv]
// Parser and emission state machine of the keyword block decoder.
// Depends on fckbd_pkg; drives commands to fckbd_dpath.
module fckbd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_block_start,
   output logic                req_stall,
   input  fckbd_pkg::sts_type  sts,
   output fckbd_pkg::cmd_type  cmd
);

   fckbd_pkg::state_type state_ff, state_in, phase;
   logic can_take, take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fckbd_pkg::ST_DONE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      can_take = sts.out_free && (state_ff == fckbd_pkg::ST_HEADER ||
                 state_ff == fckbd_pkg::ST_MATCH || state_ff == fckbd_pkg::ST_DELTA ||
                 state_ff == fckbd_pkg::ST_OFFSET || state_ff == fckbd_pkg::ST_DOCS ||
                 state_ff == fckbd_pkg::ST_HITS || state_ff == fckbd_pkg::ST_HINT ||
                 state_ff == fckbd_pkg::ST_SKIP || state_ff == fckbd_pkg::ST_DONE);
      req_stall = !can_take;
      take      = req_valid && can_take;
      phase     = req_block_start ? fckbd_pkg::ST_HEADER : state_ff;

      if (take) begin
         cmd.clr_block = req_block_start;
         unique case (phase)
            fckbd_pkg::ST_HEADER: begin
               if (sts.hdr_zero) begin
                  cmd.marker = 1'b1;
                  state_in   = fckbd_pkg::ST_DONE;
               end else if (sts.hdr_short) begin
                  if (sts.short_too_long) begin
                     cmd.marker     = 1'b1;
                     cmd.marker_err = 1'b1;
                     state_in       = fckbd_pkg::ST_DONE;
                  end else begin
                     cmd.start_short = 1'b1;
                     state_in        = fckbd_pkg::ST_DELTA;
                  end
               end else begin
                  cmd.hdr_long = 1'b1;
                  state_in     = fckbd_pkg::ST_MATCH;
               end
            end
            fckbd_pkg::ST_MATCH: begin
               if (sts.match_too_long) begin
                  cmd.marker     = 1'b1;
                  cmd.marker_err = 1'b1;
                  state_in       = fckbd_pkg::ST_DONE;
               end else begin
                  cmd.start_long = 1'b1;
                  state_in       = fckbd_pkg::ST_DELTA;
               end
            end
            fckbd_pkg::ST_DELTA: begin
               cmd.wr_delta = 1'b1;
               if (sts.delta_last) begin
                  cmd.vi_clr = 1'b1;
                  state_in   = fckbd_pkg::ST_OFFSET;
               end
            end
            fckbd_pkg::ST_OFFSET, fckbd_pkg::ST_DOCS,
            fckbd_pkg::ST_HITS, fckbd_pkg::ST_SKIP: begin
               if (sts.vi_done) begin
                  cmd.vi_clr = 1'b1;
                  unique case (phase)
                     fckbd_pkg::ST_OFFSET: begin
                        cmd.ld_offset = 1'b1;
                        state_in      = fckbd_pkg::ST_DOCS;
                     end
                     fckbd_pkg::ST_DOCS: begin
                        cmd.ld_docs = 1'b1;
                        state_in    = fckbd_pkg::ST_HITS;
                     end
                     fckbd_pkg::ST_HITS: begin
                        cmd.ld_hits = 1'b1;
                        if (sts.hint_go) begin
                           state_in = fckbd_pkg::ST_HINT;
                        end else if (sts.skip_go) begin
                           state_in = fckbd_pkg::ST_SKIP;
                        end else begin
                           cmd.clr_skip  = 1'b1;
                           cmd.emit_init = 1'b1;
                           state_in = sts.word_empty ? fckbd_pkg::ST_HEADER
                                                     : fckbd_pkg::ST_PREP;
                        end
                     end
                     default: begin
                        cmd.ld_skip   = 1'b1;
                        cmd.emit_init = 1'b1;
                        state_in = sts.word_empty ? fckbd_pkg::ST_HEADER
                                                  : fckbd_pkg::ST_PREP;
                     end
                  endcase
               end else if ((phase == fckbd_pkg::ST_DOCS || phase == fckbd_pkg::ST_HITS)
                            ? sts.vi_ovf_cnt : sts.vi_ovf_off) begin
                  cmd.marker     = 1'b1;
                  cmd.marker_err = 1'b1;
                  state_in       = fckbd_pkg::ST_DONE;
               end else begin
                  cmd.vi_shift = 1'b1;
               end
            end
            fckbd_pkg::ST_HINT: begin
               cmd.ld_hint = 1'b1;
               if (sts.skip_go) begin
                  cmd.vi_clr = 1'b1;
                  state_in   = fckbd_pkg::ST_SKIP;
               end else begin
                  cmd.clr_skip  = 1'b1;
                  cmd.emit_init = 1'b1;
                  state_in = sts.word_empty ? fckbd_pkg::ST_HEADER : fckbd_pkg::ST_PREP;
               end
            end
            default: begin
               // idle: byte dropped
            end
         endcase
      end else begin
         unique case (state_ff)
            fckbd_pkg::ST_PREP: state_in = fckbd_pkg::ST_RD;
            fckbd_pkg::ST_RD: begin
               cmd.emit_rd = 1'b1;
               state_in    = fckbd_pkg::ST_LD;
            end
            fckbd_pkg::ST_LD: begin
               if (sts.out_free) begin
                  cmd.emit_ld = 1'b1;
                  state_in = sts.emit_last ? fckbd_pkg::ST_HEADER : fckbd_pkg::ST_RD;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

[design/fckbd_dpath.sv]
// Datapath: word store, entry registers, varint accumulator, hint and output register.
// Depends on fckbd_pkg and fckbd_ram; commanded by fckbd_ctrl.
module fckbd_dpath #(
   parameter int MAX_WORD_BYTES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         data_byte,
   input  logic [30:0]        skip_size,
   input  logic [30:0]        hint_thr,
   input  fckbd_pkg::cmd_type cmd,
   output fckbd_pkg::sts_type sts,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic               rsp_kind,
   output logic [5:0]         rsp_byte_pos,
   output logic [7:0]         rsp_word_byte,
   output logic [6:0]         rsp_word_len,
   output logic [63:0]        rsp_doclist_offset,
   output logic [31:0]        rsp_doc_count,
   output logic [31:0]        rsp_hit_count,
   output logic [30:0]        rsp_doclist_hint,
   output logic [63:0]        rsp_skiplist_offset,
   output logic               rsp_last,
   output logic               rsp_format_error
);

   localparam logic [8:0] MaxLen = 9'(MAX_WORD_BYTES);

   logic [fckbd_pkg::STORE_DEPTH-1:0] valid_ff;
   logic                               rd_valid_ff;
   logic [7:0]  rd_data;
   logic [6:0]  cur_len_ff;
   logic [7:0]  delta_ff;
   logic [63:0] acc_ff;
   logic [3:0]  vbytes_ff;
   logic [63:0] offset_ff;
   logic [31:0] docs_ff;
   logic [31:0] hits_ff;
   logic [7:0]  hbyte_ff;
   logic [63:0] skip_ff;
   logic [39:0] prod_ff;
   logic [30:0] hint_ff;
   logic [6:0]  k_ff;

   logic        out_valid_ff;
   logic        out_kind_ff, out_last_ff, out_err_ff;
   logic [5:0]  out_pos_ff;
   logic [7:0]  out_byte_ff;
   logic [6:0]  out_len_ff;
   logic [63:0] out_off_ff, out_skip_ff;
   logic [31:0] out_docs_ff, out_hits_ff;
   logic [30:0] out_hint_ff;

   logic [63:0] vi_next;
   logic [3:0]  vbytes_inc;
   logic [34:0] hint_small, hint_big, hint_raw;
   logic [30:0] hint_in;

   assign vi_next    = {acc_ff[56:0], data_byte[6:0]};
   assign vbytes_inc = vbytes_ff + 4'd1;

   always_comb begin
      hint_small = {docs_ff, 3'b000};
      hint_big   = {1'b0, docs_ff, 2'b00} + {1'b0, prod_ff[39:6]};
      hint_raw   = (docs_ff < {1'b0, hint_thr}) ? hint_small : hint_big;
      hint_in    = (|hint_raw[34:31]) ? 31'h7FFF_FFFF : hint_raw[30:0];
   end

   always_comb begin
      sts.hdr_zero       = (data_byte == 8'd0);
      sts.hdr_short      = data_byte[7];
      sts.short_too_long = ({5'd0, data_byte[3:0]} + {6'd0, data_byte[6:4]} + 9'd1) > MaxLen;
      sts.match_too_long = ({1'b0, data_byte} + {1'b0, delta_ff}) > MaxLen;
      sts.delta_last     = (delta_ff == 8'd1);
      sts.vi_done        = !data_byte[7];
      sts.vi_ovf_off     = vbytes_inc >= fckbd_pkg::OFF_VARINT_MAX;
      sts.vi_ovf_cnt     = vbytes_inc >= fckbd_pkg::CNT_VARINT_MAX;
      sts.hint_go        = !docs_ff[31] && (docs_ff[30:0] >= hint_thr);
      sts.skip_go        = !docs_ff[31] && (docs_ff[30:0] > skip_size);
      sts.word_empty     = (cur_len_ff == 7'd0);
      sts.emit_last      = (k_ff == cur_len_ff - 7'd1);
      sts.out_free       = !out_valid_ff || !rsp_stall;
   end

   fckbd_ram #(
      .WIDTH (8),
      .DEPTH (fckbd_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_delta),
      .wr_addr (cur_len_ff[fckbd_pkg::STORE_AW-1:0]),
      .wr_data (data_byte),
      .rd_en   (cmd.emit_rd),
      .rd_addr (k_ff[fckbd_pkg::STORE_AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         cur_len_ff <= '0;
         delta_ff   <= '0;
         acc_ff     <= '0;
         vbytes_ff  <= '0;
         hbyte_ff   <= '0;
         offset_ff  <= '0;
         docs_ff    <= '0;
         hits_ff    <= '0;
         k_ff       <= '0;
      end else begin
         if (cmd.clr_block) begin
            valid_ff   <= '0;
            cur_len_ff <= '0;
            delta_ff   <= '0;
            acc_ff     <= '0;
            vbytes_ff  <= '0;
            hbyte_ff   <= '0;
         end
         if (cmd.hdr_long) begin
            delta_ff <= {1'b0, data_byte[6:0]};
         end
         if (cmd.start_short) begin
            delta_ff   <= {5'd0, data_byte[6:4]} + 8'd1;
            cur_len_ff <= {3'd0, data_byte[3:0]};
         end
         if (cmd.start_long) begin
            cur_len_ff <= data_byte[6:0];
         end
         if (cmd.wr_delta) begin
            valid_ff[cur_len_ff[fckbd_pkg::STORE_AW-1:0]] <= 1'b1;
            cur_len_ff <= cur_len_ff + 7'd1;
            delta_ff   <= delta_ff - 8'd1;
         end
         if (cmd.vi_shift) begin
            acc_ff    <= vi_next;
            vbytes_ff <= vbytes_inc;
         end
         if (cmd.vi_clr || cmd.marker) begin
            acc_ff    <= '0;
            vbytes_ff <= '0;
         end
         if (cmd.marker) begin
            cur_len_ff <= '0;
         end
         if (cmd.ld_offset) begin
            offset_ff <= vi_next;
         end
         if (cmd.ld_docs) begin
            docs_ff <= vi_next[31:0];
         end
         if (cmd.ld_hits) begin
            hits_ff  <= vi_next[31:0];
            hbyte_ff <= '0;
         end
         if (cmd.ld_hint) begin
            hbyte_ff <= data_byte;
         end
         if (cmd.emit_init) begin
            k_ff <= '0;
         end
         if (cmd.emit_ld) begin
            k_ff <= k_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= docs_ff * hbyte_ff;
      if (cmd.ld_skip) begin
         skip_ff <= vi_next;
      end
      if (cmd.clr_skip) begin
         skip_ff <= '0;
      end
      if (cmd.emit_rd) begin
         hint_ff     <= hint_in;
         rd_valid_ff <= valid_ff[k_ff[fckbd_pkg::STORE_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.marker || cmd.emit_ld) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.marker) begin
         out_kind_ff <= fckbd_pkg::KIND_MARKER;
         out_last_ff <= 1'b1;
         out_err_ff  <= cmd.marker_err;
         out_pos_ff  <= '0;
         out_byte_ff <= '0;
         out_len_ff  <= '0;
         out_off_ff  <= '0;
         out_docs_ff <= '0;
         out_hits_ff <= '0;
         out_hint_ff <= '0;
         out_skip_ff <= '0;
      end else if (cmd.emit_ld) begin
         out_kind_ff <= fckbd_pkg::KIND_BYTE;
         out_last_ff <= sts.emit_last;
         out_err_ff  <= 1'b0;
         out_pos_ff  <= k_ff[5:0];
         out_byte_ff <= rd_valid_ff ? rd_data : 8'd0;
         out_len_ff  <= cur_len_ff;
         out_off_ff  <= offset_ff;
         out_docs_ff <= docs_ff;
         out_hits_ff <= hits_ff;
         out_hint_ff <= hint_ff;
         out_skip_ff <= skip_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_kind            = out_kind_ff;
   assign rsp_byte_pos        = out_pos_ff;
   assign rsp_word_byte       = out_byte_ff;
   assign rsp_word_len        = out_len_ff;
   assign rsp_doclist_offset  = out_off_ff;
   assign rsp_doc_count       = out_docs_ff;
   assign rsp_hit_count       = out_hits_ff;
   assign rsp_doclist_hint    = out_hint_ff;
   assign rsp_skiplist_offset = out_skip_ff;
   assign rsp_last            = out_last_ff;
   assign rsp_format_error    = out_err_ff;

endmodule

[design/front_coded_keyword_block_decoder_core.sv]
// The first keyword byte of an entry is presented after the byte that completes the
// entry is accepted, once the controller has passed ST_PREP, ST_RD and ST_LD.
// Throughput: one stream byte per cycle while parsing unless a stalled response holds
// the output; the input stalls while a word is emitted via ST_RD and ST_LD per byte.
// Reset (synchronous): parser idle until a block start byte, word store reads as zero,
// registers back to 128 and 256. No clearing pass.
module front_coded_keyword_block_decoder_core #(
   parameter int MAX_WORD_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_block_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [5:0]  rsp_byte_pos,
   output logic [7:0]  rsp_word_byte,
   output logic [6:0]  rsp_word_len,
   output logic [63:0] rsp_doclist_offset,
   output logic [31:0] rsp_doc_count,
   output logic [31:0] rsp_hit_count,
   output logic [30:0] rsp_doclist_hint,
   output logic [63:0] rsp_skiplist_offset,
   output logic        rsp_last,
   output logic        rsp_format_error,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   `include "front_coded_keyword_block_decoder_core_assert.svh"

   logic [30:0] skip_size_ff, hint_thr_ff;
   logic        csr_wr;
   fckbd_pkg::cmd_type cmd;
   fckbd_pkg::sts_type sts;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_size_ff <= 31'd128;
         hint_thr_ff  <= 31'd256;
      end else if (csr_wr) begin
         if (paddr[2] == fckbd_pkg::CSR_IDX_SKIP) begin
            skip_size_ff <= pwdata[30:0];
         end else begin
            hint_thr_ff <= pwdata[30:0];
         end
      end
   end

   assign prdata = (paddr[2] == fckbd_pkg::CSR_IDX_SKIP) ? {1'b0, skip_size_ff}
                                                          : {1'b0, hint_thr_ff};

   fckbd_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_block_start (req_block_start),
      .req_stall       (req_stall),
      .sts             (sts),
      .cmd             (cmd)
   );

   fckbd_dpath #(
      .MAX_WORD_BYTES (MAX_WORD_BYTES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .data_byte           (req_data_byte),
      .skip_size           (skip_size_ff),
      .hint_thr            (hint_thr_ff),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_kind            (rsp_kind),
      .rsp_byte_pos        (rsp_byte_pos),
      .rsp_word_byte       (rsp_word_byte),
      .rsp_word_len        (rsp_word_len),
      .rsp_doclist_offset  (rsp_doclist_offset),
      .rsp_doc_count       (rsp_doc_count),
      .rsp_hit_count       (rsp_hit_count),
      .rsp_doclist_hint    (rsp_doclist_hint),
      .rsp_skiplist_offset (rsp_skiplist_offset),
      .rsp_last            (rsp_last),
      .rsp_format_error    (rsp_format_error)
   );

   `FCKBD_ASSERT_NOW(a_marker_last, rsp_valid && rsp_kind, rsp_last)
   `FCKBD_ASSERT_NOW(a_err_is_marker, rsp_valid && rsp_format_error, rsp_kind)
   `FCKBD_ASSERT_NOW(a_last_pos, rsp_valid && !rsp_kind && rsp_last,
                     (rsp_byte_pos + 6'd1) == rsp_word_len[5:0])
   `FCKBD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                      rsp_valid && $stable(rsp_byte_pos) && $stable(rsp_word_byte))

endmodule

[tb/sv/front_coded_keyword_block_decoder_core_tb.sv]
// Self-checking testbench for the front-coded keyword block decoder core.
// Builds keyword block streams, predicts every keyword byte and marker, checks them.
// Depends on fckbd_pkg and front_coded_keyword_block_decoder_core.
module front_coded_keyword_block_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        kind;
      logic [5:0]  pos;
      logic [7:0]  wbyte;
      logic [6:0]  wlen;
      logic [63:0] off;
      logic [31:0] docs;
      logic [31:0] hits;
      logic [30:0] hint;
      logic [63:0] skip;
      logic        last;
      logic        err;
   } kw_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid, req_stall, req_block_start;
   logic [7:0]  req_data_byte;
   logic        rsp_valid, rsp_stall, rsp_kind, rsp_last, rsp_format_error;
   logic [5:0]  rsp_byte_pos;
   logic [7:0]  rsp_word_byte;
   logic [6:0]  rsp_word_len;
   logic [63:0] rsp_doclist_offset, rsp_skiplist_offset;
   logic [31:0] rsp_doc_count, rsp_hit_count;
   logic [30:0] rsp_doclist_hint;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;

   front_coded_keyword_block_decoder_core u_dut (.*);

   // keyword decoder shadow state
   logic [7:0]  kw_store [64];
   logic [6:0]  kw_len;
   fckbd_pkg::state_type kw_phase;
   logic [7:0]  kw_delta_left;
   logic [63:0] vi_acc;
   logic [3:0]  vi_cnt;
   logic [63:0] off_r;
   logic [31:0] docs_r, hits_r;
   logic [7:0]  hintb_r;
   logic        blk_done;
   logic [30:0] cfg_skip, cfg_thr;

   kw_result_type expected_q [$];
   logic [8:0]  stream_q [$];
   int          bytes_added;
   int          fails = 0;
   int          snd_idle, rcv_idle;

   always #4 clock = ~clock;

   function automatic void push_marker(logic err);
      kw_result_type r;
      r = '0;
      r.kind = fckbd_pkg::KIND_MARKER;
      r.last = 1'b1;
      r.err  = err;
      expected_q.push_back(r);
      kw_len = '0;
      blk_done = 1'b1;
      vi_acc = '0;
      vi_cnt = '0;
   endfunction

   function automatic void emit_word(logic [63:0] sk);
      kw_result_type r;
      longint unsigned dd, hv;
      dd = 64'(docs_r);
      if (dd < cfg_thr) hv = 8 * dd;
      else hv = 4 * dd + (dd * hintb_r) / 64;
      if (hv > 64'h7FFF_FFFF) hv = 64'h7FFF_FFFF;
      for (int k = 0; k < kw_len; k++) begin
         r.kind  = fckbd_pkg::KIND_BYTE;
         r.pos   = k[5:0];
         r.wbyte = kw_store[k[5:0]];
         r.wlen  = kw_len;
         r.off   = off_r;
         r.docs  = docs_r;
         r.hits  = hits_r;
         r.hint  = hv[30:0];
         r.skip  = sk;
         r.last  = (k == kw_len - 1);
         r.err   = 1'b0;
         expected_q.push_back(r);
      end
      kw_phase = fckbd_pkg::ST_HEADER;
   endfunction

   function automatic void start_word(int m, int d);
      if (m + d > 64) begin
         push_marker(1'b1);
         return;
      end
      kw_delta_left = d[7:0];
      kw_len = m[6:0];
      kw_phase = fckbd_pkg::ST_DELTA;
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic st);
      logic [63:0] v;
      int sd, lim;
      if (st) begin
         foreach (kw_store[i]) kw_store[i] = '0;
         kw_len = '0;
         kw_phase = fckbd_pkg::ST_HEADER;
         kw_delta_left = '0;
         vi_acc = '0;
         vi_cnt = '0;
         hintb_r = '0;
         blk_done = 1'b0;
      end else if (blk_done) return;
      sd = int'(docs_r);
      case (kw_phase)
         fckbd_pkg::ST_HEADER: begin
            if (b == 8'h00) push_marker(1'b0);
            else if (b[7]) start_word(int'(b[3:0]), int'(b[6:4]) + 1);
            else begin
               kw_delta_left = {1'b0, b[6:0]};
               kw_phase = fckbd_pkg::ST_MATCH;
            end
         end
         fckbd_pkg::ST_MATCH: start_word(int'(b), int'(kw_delta_left));
         fckbd_pkg::ST_DELTA: begin
            kw_store[kw_len[5:0]] = b;
            kw_len = kw_len + 7'd1;
            kw_delta_left = kw_delta_left - 8'd1;
            if (kw_delta_left == 0) begin
               kw_phase = fckbd_pkg::ST_OFFSET;
               vi_acc = '0;
               vi_cnt = '0;
            end
         end
         fckbd_pkg::ST_OFFSET, fckbd_pkg::ST_DOCS, fckbd_pkg::ST_HITS,
         fckbd_pkg::ST_SKIP: begin
            lim = (kw_phase == fckbd_pkg::ST_DOCS || kw_phase == fckbd_pkg::ST_HITS)
                  ? int'(fckbd_pkg::CNT_VARINT_MAX) : int'(fckbd_pkg::OFF_VARINT_MAX);
            vi_acc = (vi_acc << 7) | {57'b0, b[6:0]};
            vi_cnt = vi_cnt + 4'd1;
            if (b[7]) begin
               if (vi_cnt >= lim) push_marker(1'b1);
               return;
            end
            v = vi_acc;
            vi_acc = '0;
            vi_cnt = '0;
            case (kw_phase)
               fckbd_pkg::ST_OFFSET: begin off_r = v; kw_phase = fckbd_pkg::ST_DOCS; end
               fckbd_pkg::ST_DOCS: begin docs_r = v[31:0]; kw_phase = fckbd_pkg::ST_HITS; end
               fckbd_pkg::ST_HITS: begin
                  hits_r = v[31:0];
                  hintb_r = '0;
                  if (sd >= int'({1'b0, cfg_thr})) kw_phase = fckbd_pkg::ST_HINT;
                  else if (sd > int'({1'b0, cfg_skip})) kw_phase = fckbd_pkg::ST_SKIP;
                  else emit_word('0);
               end
               default: emit_word(v);
            endcase
         end
         fckbd_pkg::ST_HINT: begin
            hintb_r = b;
            if (sd > int'({1'b0, cfg_skip})) begin
               kw_phase = fckbd_pkg::ST_SKIP;
               vi_acc = '0;
               vi_cnt = '0;
            end else emit_word('0);
         end
         default: kw_phase = fckbd_pkg::ST_HEADER;
      endcase
   endfunction

   task automatic put(input logic [7:0] b, input logic st = 1'b0);
      stream_q.push_back({st, b});
      bytes_added++;
   endtask

   task automatic put_varint(input logic [63:0] v, input int nmax);
      int n;
      n = 1;
      while (n < nmax && (v >> (7 * n)) != 0) n++;
      for (int i = n - 1; i >= 0; i--)
         put({i != 0, 7'((v >> (7 * i)) & 64'h7F)});
   endtask

   task automatic put_entry(input logic st, input bit long_form, input int m, input int d,
                            input logic [63:0] off, input logic [63:0] docs,
                            input logic [31:0] hits, input logic [7:0] hb,
                            input logic [63:0] sk);
      int sd;
      if (!long_form) put({1'b1, 3'(d - 1), 4'(m)}, st);
      else begin
         put(8'(d), st);
         put(8'(m));
      end
      if (m + d > 64) return;
      repeat (d) put(8'($urandom));
      put_varint(off, 10);
      put_varint(docs, 5);
      put_varint({32'b0, hits}, 5);
      sd = int'(docs[31:0]);
      if (sd >= int'({1'b0, cfg_thr})) put(hb);
      if (sd > int'({1'b0, cfg_skip})) put_varint(sk, 10);
   endtask

   task automatic rand_entry(input logic st);
      bit lf;
      int m, d;
      logic [63:0] off, docs;
      lf = 1'($urandom_range(1));
      if (!lf) begin
         d = $urandom_range(1, 8);
         m = $urandom_range(0, 15);
      end else begin
         d = ($urandom_range(7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 10);
         m = $urandom_range(0, 64 - d);
      end
      case ($urandom_range(2))
         0: off = 64'($urandom_range(0, 200));
         1: off = {$urandom, $urandom};
         default: off = 64'($urandom);
      endcase
      case ($urandom_range(7))
         0, 1, 2: docs = 64'($urandom_range(0, 40));
         3: docs = {32'b0, 32'(cfg_thr + $urandom_range(2) - 1)};
         4: docs = {32'b0, 32'(cfg_skip + $urandom_range(2) - 1)};
         5: docs = {32'b0, 1'b1, 31'($urandom)};
         6: docs = {32'b0, $urandom};
         default: docs = {29'b0, 3'($urandom), $urandom};
      endcase
      put_entry(st, lf, m, d, off, docs, ($urandom_range(1) ? $urandom : $urandom_range(0, 99)),
                8'($urandom), {$urandom, $urandom});
   endtask

   task automatic rand_block();
      rand_entry(1'b1);
      repeat ($urandom_range(0, 1)) rand_entry(1'b0);
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: put(8'h00);
         6: put_entry(1'b0, 1'b1, $urandom_range(5, 255), 60, 0, 0, 0, 0, 0);
         7: begin
            put(8'h80);
            put(8'($urandom));
            repeat (10) put({1'b1, 7'($urandom)});
         end
         8: begin
            put(8'h80);
            put(8'($urandom));
            put_varint(64'($urandom), 10);
            repeat (5) put({1'b1, 7'($urandom)});
         end
         default: ;
      endcase
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) put(8'($urandom));
   endtask

   task automatic csr_write(input logic [2:0] a, input logic [31:0] v);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (a == 3'd0) cfg_skip = v[30:0];
      else cfg_thr = v[30:0];
   endtask

   task automatic wait_drained();
      while (stream_q.size() != 0 || req_valid || expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         $error("%s mismatch: expected %0h, actual %0h", name, e, a);
         fails++;
      end
   endfunction

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data_byte <= '0;
         req_block_start <= 1'b0;
         foreach (kw_store[i]) kw_store[i] = '0;
         kw_len = '0; kw_phase = fckbd_pkg::ST_HEADER; kw_delta_left = '0;
         vi_acc = '0; vi_cnt = '0;
         off_r = '0; docs_r = '0; hits_r = '0; hintb_r = '0; blk_done = 1'b1;
      end else begin
         if (req_valid && !req_stall) decode_byte(req_data_byte, req_block_start);
         if (!req_valid || !req_stall) begin
            if (stream_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
               {req_block_start, req_data_byte} <= stream_q.pop_front();
               req_valid <= 1'b1;
            end else req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      kw_result_type e;
      if (reset) rsp_stall <= 1'b0;
      else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result transaction");
               fails++;
            end else begin
               e = expected_q.pop_front();
               check_field("kind", 64'(e.kind), 64'(rsp_kind));
               check_field("byte_pos", 64'(e.pos), 64'(rsp_byte_pos));
               check_field("word_byte", 64'(e.wbyte), 64'(rsp_word_byte));
               check_field("word_len", 64'(e.wlen), 64'(rsp_word_len));
               check_field("doclist_offset", e.off, rsp_doclist_offset);
               check_field("doc_count", 64'(e.docs), 64'(rsp_doc_count));
               check_field("hit_count", 64'(e.hits), 64'(rsp_hit_count));
               check_field("doclist_hint", 64'(e.hint), 64'(rsp_doclist_hint));
               check_field("skiplist_offset", e.skip, rsp_skiplist_offset);
               check_field("last", 64'(e.last), 64'(rsp_last));
               check_field("format_error", 64'(e.err), 64'(rsp_format_error));
            end
         end
         rsp_stall <= ($urandom_range(99) < rcv_idle);
      end
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [30:0] skip_set [5];
      logic [30:0] thr_set [5];
      skip_set = '{31'd128, 31'd1, 31'h7FFF_FFFF, 31'd20, 31'd300};
      thr_set  = '{31'd256, 31'd0, 31'h7FFF_FFFF, 31'd40, 31'd100};
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      cfg_skip = 31'd128; cfg_thr = 31'd256;
      snd_idle = 6; rcv_idle = 56;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 5; p++) begin
         snd_idle = (p < 2) ? 6 : (p < 4) ? 56 : 0;
         rcv_idle = (p < 2) ? 56 : (p < 4) ? 6 : 0;
         if (p > 0) begin
            wait_drained();
            csr_write(3'd0, {1'b0, skip_set[p]});
            csr_write(3'd4, {1'b0, thr_set[p]});
         end else begin
            put(8'h33);
            put_entry(1'b1, 1'b0, 0, 1, 0, 0, 0, 0, 0);
            put_entry(1'b0, 1'b1, 60, 4, '1, 64'hFFFF_FFFF, '1, 0, 0);
            put_entry(1'b0, 1'b0, 15, 8, 64'h7F, 256, 32'h8000_0000, 8'hFF, '1);
            put_entry(1'b0, 1'b1, 30, 4, 5, 129, 1, 0, 64'h1234);
            put_entry(1'b0, 1'b0, 2, 3, 9, 128, 7, 0, 0);
            put_entry(1'b0, 1'b0, 1, 2, 1, 64'h7_0000_0005, 3, 0, 0);
            put(8'h00);
            put(8'h55);
            put_entry(1'b1, 1'b1, 10, 60, 0, 0, 0, 0, 0);
            put(8'h12);
            put(8'h80, 1'b1); put(8'hAA);
            repeat (10) put(8'hFF);
            put(8'h80, 1'b1); put(8'h01); put(8'h00);
            repeat (5) put(8'hFF);
            put_entry(1'b1, 1'b0, 0, 4, 1, 2, 3, 0, 0);
            put_entry(1'b1, 1'b0, 7, 1, 1, 2, 3, 0, 0);
            put(8'h00);
         end
         bytes_added = 0;
         while (p > 0 && bytes_added < 10) rand_block();
      end
      wait_drained();
      if (fails == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/fckbd_pkg.sv
design/fckbd_ram.sv
design/fckbd_ctrl.sv
design/fckbd_dpath.sv
design/front_coded_keyword_block_decoder_core.sv
tb/sv/front_coded_keyword_block_decoder_core_tb.sv
